// ===== sv/vfc_pkg.sv =====
// ----------------------------------------------------------------------------
// vfc_pkg: shared types and constants of the voxel face cull mesher
// Field widths, item modes, face direction codes and controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package vfc_pkg;

  localparam int unsigned COORD_W = 4;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned VERT_W  = 16;
  localparam int unsigned DIR_W   = 3;
  localparam int unsigned POS_W   = 3 * COORD_W;
  localparam int unsigned FACES   = 6;

  localparam logic MODE_PLACE = 1'b0;
  localparam logic MODE_MESH  = 1'b1;

  localparam logic [DIR_W-1:0] DIR_PX  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_NX  = 3'd1;
  localparam logic [DIR_W-1:0] DIR_PY  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_NY  = 3'd3;
  localparam logic [DIR_W-1:0] DIR_PZ  = 3'd4;
  localparam logic [DIR_W-1:0] DIR_NZ  = 3'd5;
  localparam logic [DIR_W-1:0] DIR_END = 3'd6;

  localparam logic [VERT_W-1:0] VERT_STEP = 16'd4;

  typedef struct packed {
    logic clr_step;     // zero one grid cell of the reset sweep
    logic place;        // write grid cell and append to list
    logic mesh_start;   // mesh item taken: read list entry
    logic list_done;    // list entry ready: latch position, read center
    logic center_done;  // center block ready: latch it, reset scan
    logic scan_step;    // one neighbor read / evaluate step
    logic emit_face;    // load output register with next open face
    logic emit_blank;   // load output register with a faceless result
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic idx_oob;
    logic blk_zero;
    logic scan_done;
    logic mask_any;
    logic face_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/vfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// vfc_ctrl: sequencing controller
// Grid clear sweep after reset, then one item at a time: place on accept,
// mesh through list read, center read, neighbor scan and emission.
// ----------------------------------------------------------------------------
`default_nettype none

module vfc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          mode_i,
  output logic               in_ready_o,
  input  vfc_pkg::sts_t      sts_i,
  output vfc_pkg::cmd_t      cmd_o
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_LIST   = 7'b0000100,
    S_CENTER = 7'b0001000,
    S_SCAN   = 7'b0010000,
    S_FACE   = 7'b0100000,
    S_BLANK  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (mode_i == vfc_pkg::MODE_PLACE) begin
            cmd_o.place = 1'b1;
          end else begin
            cmd_o.mesh_start = 1'b1;
            state_d = sts_i.idx_oob ? S_BLANK : S_LIST;
          end
        end
      end
      S_LIST: begin
        cmd_o.list_done = 1'b1;
        state_d = S_CENTER;
      end
      S_CENTER: begin
        cmd_o.center_done = 1'b1;
        state_d = sts_i.blk_zero ? S_BLANK : S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) state_d = S_FACE;
      end
      S_FACE: begin
        if (!sts_i.mask_any) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit_face = 1'b1;
          if (sts_i.face_last) state_d = S_IDLE;
        end
      end
      S_BLANK: begin
        if (sts_i.out_free) begin
          cmd_o.emit_blank = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/vfc_datapath.sv =====
// ----------------------------------------------------------------------------
// vfc_datapath: grid and list memories, counters, face mask, output register
// One grid write port serves the clear sweep and placement; one read port serves all mesh reads.
// ----------------------------------------------------------------------------
`default_nettype none

module vfc_datapath #(
  parameter int unsigned GRID_EDGE  = 16,
  parameter int unsigned LIST_DEPTH = 4096
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  vfc_pkg::cmd_t                      cmd_i,
  output vfc_pkg::sts_t                      sts_o,
  input  wire logic [vfc_pkg::COORD_W-1:0]   place_x_i,
  input  wire logic [vfc_pkg::COORD_W-1:0]   place_y_i,
  input  wire logic [vfc_pkg::COORD_W-1:0]   place_z_i,
  input  wire logic [vfc_pkg::ID_W-1:0]      block_id_i,
  input  wire logic [vfc_pkg::IDX_W-1:0]     list_index_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic                               face_valid_o,
  output logic [vfc_pkg::COORD_W-1:0]        cell_x_o,
  output logic [vfc_pkg::COORD_W-1:0]        cell_y_o,
  output logic [vfc_pkg::COORD_W-1:0]        cell_z_o,
  output logic [vfc_pkg::DIR_W-1:0]          face_dir_o,
  output logic [vfc_pkg::VERT_W-1:0]         first_vertex_o,
  output logic [vfc_pkg::ID_W-1:0]           cell_block_o,
  output logic                               last_o
);

  localparam int unsigned CW     = $clog2(GRID_EDGE);
  localparam int unsigned GAW    = 3 * CW;
  localparam int unsigned GDEPTH = 1 << GAW;
  localparam int unsigned LAW    = $clog2(LIST_DEPTH);
  localparam int unsigned LCW    = $clog2(LIST_DEPTH + 1);
  localparam logic [5:0]  EDGE   = 6'(GRID_EDGE);
  localparam logic [5:0]  EDGE_M = 6'(GRID_EDGE - 1);

  localparam int unsigned CO = vfc_pkg::COORD_W;
  localparam int unsigned PW = vfc_pkg::POS_W;
  localparam int unsigned DW = vfc_pkg::DIR_W;
  localparam int unsigned VW = vfc_pkg::VERT_W;
  localparam int unsigned IW = vfc_pkg::ID_W;
  localparam int unsigned NF = vfc_pkg::FACES;

  // memories
  logic [IW-1:0] grid_mem [GDEPTH];
  logic [PW-1:0] list_mem [LIST_DEPTH];

  logic [GAW-1:0] clr_addr_q;
  logic [LCW-1:0] list_cnt_q;
  logic [VW-1:0]  vc_q;
  logic [PW-1:0]  pos_q;
  logic [IW-1:0]  blk_q;
  logic [PW-1:0]  list_rd_q;
  logic [IW-1:0]  grid_rd_q;
  logic [DW-1:0]  k_q;
  logic           pend_vld_q;
  logic [DW-1:0]  pend_dir_q;
  logic           pend_oob_q;
  logic [NF-1:0]  mask_q;

  logic           out_valid_q;
  logic           face_valid_q;
  logic [PW-1:0]  out_pos_q;
  logic [DW-1:0]  face_dir_q;
  logic [VW-1:0]  first_vertex_q;
  logic [IW-1:0]  cell_block_q;
  logic           last_q;

  // place decode
  logic           place_in;
  logic           list_room;
  logic [GAW-1:0] place_addr;
  logic [5:0]     px6, py6, pz6;

  assign px6 = 6'(place_x_i);
  assign py6 = 6'(place_y_i);
  assign pz6 = 6'(place_z_i);
  assign place_in   = (px6 < EDGE) && (py6 < EDGE) && (pz6 < EDGE);
  assign list_room  = list_cnt_q < LCW'(LIST_DEPTH);
  assign place_addr = {px6[CW-1:0], py6[CW-1:0], pz6[CW-1:0]};

  logic [31:0]    idx_ext;
  logic [LAW-1:0] list_rd_addr;
  assign idx_ext      = 32'(list_index_i);
  assign list_rd_addr = idx_ext[LAW-1:0];

  // center position from list data, neighbor from latched position
  logic [5:0]     lx6, ly6, lz6;
  logic [GAW-1:0] center_addr;
  assign lx6 = 6'(list_rd_q[PW-1 -: CO]);
  assign ly6 = 6'(list_rd_q[2*CO-1 -: CO]);
  assign lz6 = 6'(list_rd_q[CO-1:0]);
  assign center_addr = {lx6[CW-1:0], ly6[CW-1:0], lz6[CW-1:0]};

  logic [5:0]     cx6, cy6, cz6, nx6, ny6, nz6;
  logic           nb_oob;
  logic [GAW-1:0] nb_addr;
  assign cx6 = 6'(pos_q[PW-1 -: CO]);
  assign cy6 = 6'(pos_q[2*CO-1 -: CO]);
  assign cz6 = 6'(pos_q[CO-1:0]);

  always_comb begin
    nx6    = cx6;
    ny6    = cy6;
    nz6    = cz6;
    nb_oob = 1'b0;
    case (k_q)
      vfc_pkg::DIR_PX: begin nx6 = cx6 + 6'd1; nb_oob = (cx6 >= EDGE_M); end
      vfc_pkg::DIR_NX: begin nx6 = cx6 - 6'd1; nb_oob = (cx6 == 6'd0);   end
      vfc_pkg::DIR_PY: begin ny6 = cy6 + 6'd1; nb_oob = (cy6 >= EDGE_M); end
      vfc_pkg::DIR_NY: begin ny6 = cy6 - 6'd1; nb_oob = (cy6 == 6'd0);   end
      vfc_pkg::DIR_PZ: begin nz6 = cz6 + 6'd1; nb_oob = (cz6 >= EDGE_M); end
      vfc_pkg::DIR_NZ: begin nz6 = cz6 - 6'd1; nb_oob = (cz6 == 6'd0);   end
      default: nb_oob = 1'b1;
    endcase
  end
  assign nb_addr = {nx6[CW-1:0], ny6[CW-1:0], nz6[CW-1:0]};

  // grid port
  logic           scan_rd;
  logic           grid_we, grid_re;
  logic [GAW-1:0] grid_wa, grid_ra;
  logic [IW-1:0]  grid_wd;

  assign scan_rd = cmd_i.scan_step && (k_q != vfc_pkg::DIR_END);
  assign grid_we = cmd_i.clr_step | (cmd_i.place & place_in);
  assign grid_wa = cmd_i.clr_step ? clr_addr_q : place_addr;
  assign grid_wd = cmd_i.clr_step ? '0 : block_id_i;
  assign grid_re = cmd_i.list_done | scan_rd;
  assign grid_ra = cmd_i.list_done ? center_addr : nb_addr;

  always_ff @(posedge clk_i) begin
    if (grid_we) grid_mem[grid_wa] <= grid_wd;
    if (grid_re) grid_rd_q <= grid_mem[grid_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.place && place_in && list_room) begin
      list_mem[list_cnt_q[LAW-1:0]] <= {place_x_i, place_y_i, place_z_i};
    end
    if (cmd_i.mesh_start) list_rd_q <= list_mem[list_rd_addr];
  end

  // lowest open face
  logic [DW-1:0] sel;
  logic [NF-1:0] sel_oh, mask_rest;
  always_comb begin
    sel = '0;
    for (int i = NF - 1; i >= 0; i--) begin
      if (mask_q[i]) sel = DW'(i);
    end
  end
  assign sel_oh    = NF'(1) << sel;
  assign mask_rest = mask_q & ~sel_oh;

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      list_cnt_q  <= '0;
      vc_q        <= '0;
      k_q         <= '0;
      pend_vld_q  <= 1'b0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) clr_addr_q <= clr_addr_q + GAW'(1);
      if (cmd_i.place && place_in && list_room) list_cnt_q <= list_cnt_q + LCW'(1);
      if (cmd_i.mesh_start && (list_index_i == '0)) vc_q <= '0;
      else if (cmd_i.emit_face) vc_q <= vc_q + vfc_pkg::VERT_STEP;
      if (cmd_i.center_done) begin
        k_q        <= '0;
        pend_vld_q <= 1'b0;
        mask_q     <= '0;
      end else if (cmd_i.scan_step) begin
        k_q        <= k_q + DW'(1);
        pend_vld_q <= scan_rd;
        if (pend_vld_q) mask_q[pend_dir_q] <= pend_oob_q | (grid_rd_q == '0);
      end else if (cmd_i.emit_face) begin
        mask_q <= mask_rest;
      end
      out_valid_q <= cmd_i.emit_face | cmd_i.emit_blank | (out_valid_q & ~out_ready_i);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.mesh_start) pos_q <= '0;
    else if (cmd_i.list_done) pos_q <= list_rd_q;
    if (cmd_i.center_done) blk_q <= grid_rd_q;
    if (scan_rd) begin
      pend_dir_q <= k_q;
      pend_oob_q <= nb_oob;
    end
    if (cmd_i.emit_face) begin
      face_valid_q   <= 1'b1;
      out_pos_q      <= pos_q;
      face_dir_q     <= sel;
      first_vertex_q <= vc_q;
      cell_block_q   <= blk_q;
      last_q         <= (mask_rest == '0);
    end else if (cmd_i.emit_blank) begin
      face_valid_q   <= 1'b0;
      out_pos_q      <= pos_q;
      face_dir_q     <= vfc_pkg::DIR_PX;
      first_vertex_q <= vc_q;
      cell_block_q   <= '0;
      last_q         <= 1'b1;
    end
  end

  always_comb begin
    sts_o.clr_last  = (clr_addr_q == GAW'(GDEPTH - 1));
    sts_o.idx_oob   = (idx_ext >= 32'(LIST_DEPTH));
    sts_o.blk_zero  = (grid_rd_q == '0);
    sts_o.scan_done = (k_q == vfc_pkg::DIR_END);
    sts_o.mask_any  = (mask_q != '0);
    sts_o.face_last = (mask_rest == '0);
    sts_o.out_free  = out_free;
  end

  assign out_valid_o    = out_valid_q;
  assign face_valid_o   = face_valid_q;
  assign cell_x_o       = out_pos_q[PW-1 -: CO];
  assign cell_y_o       = out_pos_q[2*CO-1 -: CO];
  assign cell_z_o       = out_pos_q[CO-1:0];
  assign face_dir_o     = face_dir_q;
  assign first_vertex_o = first_vertex_q;
  assign cell_block_o   = cell_block_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

// ===== sv/voxel_face_cull_mesher.sv =====
// ----------------------------------------------------------------------------
// voxel_face_cull_mesher: voxel grid with position list and face culling
// Place items fill the grid and list; mesh items emit the open faces of a
// listed block with running base vertex indices.
// Place item: written when accepted. Mesh item: accept, list read, center
//   read, then a neighbor scan of six reads on the grid read port and one
//   drain step, then one result per cycle while the output is free, one per
//   open face. A fully hidden block yields no result.
// An empty center block or an index past the list gives one faceless
//   result; one item is worked at a time.
// Reset clears all 2**(3*clog2(GRID_EDGE)) grid cells in a sweep during
//   which no item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_face_cull_mesher #(
  parameter int unsigned GRID_EDGE  = 16,
  parameter int unsigned LIST_DEPTH = 4096
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          mode_i,
  input  wire logic [vfc_pkg::COORD_W-1:0]   place_x_i,
  input  wire logic [vfc_pkg::COORD_W-1:0]   place_y_i,
  input  wire logic [vfc_pkg::COORD_W-1:0]   place_z_i,
  input  wire logic [vfc_pkg::ID_W-1:0]      block_id_i,
  input  wire logic [vfc_pkg::IDX_W-1:0]     list_index_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               face_valid_o,
  output logic [vfc_pkg::COORD_W-1:0]        cell_x_o,
  output logic [vfc_pkg::COORD_W-1:0]        cell_y_o,
  output logic [vfc_pkg::COORD_W-1:0]        cell_z_o,
  output logic [vfc_pkg::DIR_W-1:0]          face_dir_o,
  output logic [vfc_pkg::VERT_W-1:0]         first_vertex_o,
  output logic [vfc_pkg::ID_W-1:0]           cell_block_o,
  output logic                               last_o
);

  vfc_pkg::cmd_t cmd;
  vfc_pkg::sts_t sts;

  vfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vfc_datapath #(
    .GRID_EDGE  (GRID_EDGE),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .place_x_i      (place_x_i),
    .place_y_i      (place_y_i),
    .place_z_i      (place_z_i),
    .block_id_i     (block_id_i),
    .list_index_i   (list_index_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .face_valid_o   (face_valid_o),
    .cell_x_o       (cell_x_o),
    .cell_y_o       (cell_y_o),
    .cell_z_o       (cell_z_o),
    .face_dir_o     (face_dir_o),
    .first_vertex_o (first_vertex_o),
    .cell_block_o   (cell_block_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire
